// File: hdl/hse_pkg.sv
// shared types and constants for the heap sort engine
`timescale 1ns / 1ps

package hse_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int ADDR_W        = 6;
   localparam int CNT_W         = 7;
   localparam int DATA_W        = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
      logic                     overflow;
   } rsp_type;

   // write data select
   localparam logic [1:0] WR_REQ   = 2'd0;
   localparam logic [1:0] WR_CUR   = 2'd1;
   localparam logic [1:0] WR_CHILD = 2'd2;
   localparam logic [1:0] WR_ROOT  = 2'd3;

   // sift value register select
   localparam logic [1:0] CUR_HOLD = 2'd0;
   localparam logic [1:0] CUR_RDA  = 2'd1;
   localparam logic [1:0] CUR_RDB  = 2'd2;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [1:0]        wr_sel;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic [1:0]        cur_sel;
      logic              use_right;
   } cmd_type;

   typedef struct packed {
      logic child_gt;
      logic pick_right;
   } sts_type;

endpackage

// File: hdl/hse_datapath.sv
// value store, sift register and child compare of the heap sort engine
`timescale 1ns / 1ps

module hse_datapath #(
   parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  hse_pkg::req_type                   req_word,
   input  hse_pkg::cmd_type                   cmd,
   output hse_pkg::sts_type                   sts,
   output logic signed [hse_pkg::DATA_W-1:0]  rd_value
);
   import hse_pkg::*;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_a_ff;
   logic signed [DATA_W-1:0] rd_b_ff;
   logic signed [DATA_W-1:0] cur_ff;
   logic signed [DATA_W-1:0] cur_in;
   logic signed [DATA_W-1:0] child_val;
   logic signed [DATA_W-1:0] wr_data;
   logic                     pick_right;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[cmd.rd_addr_a];
      rd_b_ff <= mem[cmd.rd_addr_b];
      cur_ff  <= cur_in;
   end

   // larger child, left on ties
   assign pick_right = cmd.use_right && (rd_b_ff > rd_a_ff);
   assign child_val  = pick_right ? rd_b_ff : rd_a_ff;

   always_comb begin
      case (cmd.wr_sel)
         WR_REQ:   wr_data = req_word.value;
         WR_CUR:   wr_data = cur_ff;
         WR_CHILD: wr_data = child_val;
         WR_ROOT:  wr_data = rd_a_ff;
         default:  wr_data = cur_ff;
      endcase
   end

   always_comb begin
      case (cmd.cur_sel)
         CUR_HOLD: cur_in = cur_ff;
         CUR_RDA:  cur_in = rd_a_ff;
         CUR_RDB:  cur_in = rd_b_ff;
         default:  cur_in = cur_ff;
      endcase
   end

   assign sts.pick_right = pick_right;
   assign sts.child_gt   = child_val > cur_ff;
   assign rd_value       = rd_a_ff;

endmodule

// File: hdl/hse_ctrl.sv
// load, heap build, extraction and readout sequencer of the heap sort engine
`timescale 1ns / 1ps

module hse_ctrl #(
   parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  hse_pkg::req_type  req_word,
   output logic              busy,
   output hse_pkg::cmd_type  cmd,
   input  hse_pkg::sts_type  sts,
   output logic              rsp_valid,
   output logic              rsp_last,
   output logic              rsp_overflow
);
   import hse_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_BLD_INIT = 4'd1;
   localparam logic [3:0] ST_BLD_RD   = 4'd2;
   localparam logic [3:0] ST_BLD_CUR  = 4'd3;
   localparam logic [3:0] ST_CHK      = 4'd4;
   localparam logic [3:0] ST_CMP      = 4'd5;
   localparam logic [3:0] ST_SWP_RD   = 4'd6;
   localparam logic [3:0] ST_SWP_WR   = 4'd7;
   localparam logic [3:0] ST_OUT      = 4'd8;
   localparam logic [3:0] ST_FLUSH    = 4'd9;

   logic [3:0]        state_ff,   state_in;
   logic [CNT_W-1:0]  count_ff,   count_in;
   logic              dropped_ff, dropped_in;
   logic              extract_ff, extract_in;
   logic [ADDR_W-1:0] node_ff,    node_in;
   logic [ADDR_W-1:0] build_ff,   build_in;
   logic [ADDR_W-1:0] end_ff,     end_in;
   logic [CNT_W-1:0]  out_idx_ff, out_idx_in;
   logic              valid_ff,   valid_in;
   logic              last_ff,    last_in;

   logic [CNT_W-1:0]  left_w;
   logic [CNT_W-1:0]  right_w;
   logic [CNT_W-1:0]  last_w;
   logic [CNT_W-1:0]  count_m2;
   logic [3:0]        done_state;

   assign left_w   = {node_ff, 1'b1};
   assign right_w  = left_w + CNT_W'(1);
   assign last_w   = {1'b0, end_ff};
   assign count_m2 = count_ff - CNT_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         extract_ff <= 1'b0;
         node_ff    <= '0;
         build_ff   <= '0;
         end_ff     <= '0;
         out_idx_ff <= '0;
         valid_ff   <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         extract_ff <= extract_in;
         node_ff    <= node_in;
         build_ff   <= build_in;
         end_ff     <= end_in;
         out_idx_ff <= out_idx_in;
         valid_ff   <= valid_in;
         last_ff    <= last_in;
      end
   end

   // where to go once a sift has settled
   always_comb begin
      if (!extract_ff) begin
         done_state = (build_ff == '0) ? ST_SWP_RD : ST_BLD_RD;
      end else begin
         done_state = (end_ff == '0) ? ST_OUT : ST_SWP_RD;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      extract_in = extract_ff;
      node_in    = node_ff;
      build_in   = build_ff;
      end_in     = end_ff;
      out_idx_in = out_idx_ff;
      valid_in   = 1'b0;
      last_in    = 1'b0;
      cmd        = '0;
      cmd.wr_sel  = WR_CUR;
      cmd.cur_sel = CUR_HOLD;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = count_ff[ADDR_W-1:0];
                  cmd.wr_sel  = WR_REQ;
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_word.last_in) begin
                  state_in = ST_BLD_INIT;
               end
            end
         end
         ST_BLD_INIT: begin
            if (count_ff < CNT_W'(2)) begin
               state_in = ST_OUT;
            end else begin
               end_in   = ADDR_W'(count_ff - CNT_W'(1));
               build_in = count_m2[ADDR_W:1];
               state_in = ST_BLD_RD;
            end
         end
         ST_BLD_RD: begin
            cmd.rd_addr_a = build_ff;
            node_in       = build_ff;
            state_in      = ST_BLD_CUR;
         end
         ST_BLD_CUR: begin
            cmd.cur_sel = CUR_RDA;
            state_in    = ST_CHK;
         end
         ST_CHK: begin
            if (left_w > last_w) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = node_ff;
               cmd.wr_sel  = WR_CUR;
               if (!extract_ff && build_ff == '0) begin
                  extract_in = 1'b1;
               end else if (!extract_ff) begin
                  build_in = build_ff - ADDR_W'(1);
               end
               state_in = done_state;
            end else begin
               cmd.rd_addr_a = left_w[ADDR_W-1:0];
               cmd.rd_addr_b = (right_w > last_w) ? left_w[ADDR_W-1:0]
                                                  : right_w[ADDR_W-1:0];
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.use_right = right_w <= last_w;
            cmd.wr_en     = 1'b1;
            cmd.wr_addr   = node_ff;
            if (sts.child_gt) begin
               cmd.wr_sel = WR_CHILD;
               node_in    = sts.pick_right ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];
               state_in   = ST_CHK;
            end else begin
               cmd.wr_sel = WR_CUR;
               if (!extract_ff && build_ff == '0) begin
                  extract_in = 1'b1;
               end else if (!extract_ff) begin
                  build_in = build_ff - ADDR_W'(1);
               end
               state_in = done_state;
            end
         end
         ST_SWP_RD: begin
            cmd.rd_addr_a = '0;
            cmd.rd_addr_b = end_ff;
            state_in      = ST_SWP_WR;
         end
         ST_SWP_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = end_ff;
            cmd.wr_sel  = WR_ROOT;
            cmd.cur_sel = CUR_RDB;
            node_in     = '0;
            end_in      = end_ff - ADDR_W'(1);
            state_in    = ST_CHK;
         end
         ST_OUT: begin
            cmd.rd_addr_a = out_idx_ff[ADDR_W-1:0];
            out_idx_in    = out_idx_ff + CNT_W'(1);
            valid_in      = 1'b1;
            last_in       = (out_idx_ff + CNT_W'(1)) == count_ff;
            if (last_in) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            count_in   = '0;
            dropped_in = 1'b0;
            extract_in = 1'b0;
            out_idx_in = '0;
            end_in     = '0;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy         = state_ff != ST_IDLE;
   assign rsp_valid    = valid_ff;
   assign rsp_last     = last_ff;
   assign rsp_overflow = dropped_ff;

endmodule

// File: hdl/heap_sort_engine.sv
// heap sort engine top level
`timescale 1ns / 1ps

//  channel   ports                       handshake
//  input     start, busy, req_word       word taken when start high and busy low
//  result    rsp_valid, rsp_word         word shown for one cycle, always taken
//
// loading takes one cycle per word; the final word starts the sort.
// a batch of n words is built into a heap, then sorted by repeated extraction,
// each level of a sift writing the value store through its single write port;
// the sorted words then stream out one word per cycle.
// busy stays high from the final word until the last result has gone out.
// reset is synchronous; the value store is not cleared.

module heap_sort_engine #(
   parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hse_pkg::req_type req_word,
   output logic             rsp_valid,
   output hse_pkg::rsp_type rsp_word
);
   import hse_pkg::*;

   cmd_type                  cmd;
   sts_type                  sts;
   logic signed [DATA_W-1:0] rd_value;
   logic                     rsp_last;
   logic                     rsp_overflow;

   hse_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_word     (req_word),
      .busy         (busy),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_last     (rsp_last),
      .rsp_overflow (rsp_overflow)
   );

   hse_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock    (clock),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rd_value (rd_value)
   );

   assign rsp_word.sorted_value = rd_value;
   assign rsp_word.last_out     = rsp_last;
   assign rsp_word.overflow     = rsp_overflow;

endmodule
